/* sv/spfb_pkg.sv */
// ----------------------------------------------------------------------------
// spfb_pkg
// Shared types and constants of the stepper position frame builder.
// ----------------------------------------------------------------------------
package spfb_pkg;

  typedef enum logic [1:0] {
    OP_VEL   = 2'd0,
    OP_TIMED = 2'd1,
    OP_SYNC  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_GEARED_LIMIT = 2'd0;
  localparam logic [1:0] CFG_GEAR_RATIO   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_ACC  = 2'd2;
  localparam logic [1:0] CFG_PULSES_TURN  = 2'd3;

  localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
  localparam logic [16:0] ACC_K_Q15    = 17'd67021;
  localparam logic [20:0] SIXTY_PI_Q16 = 21'd1251645;
  localparam logic [23:0] HALF_257_Q15 = 24'd8404992;
  localparam logic [55:0] PULSE_SAT    = {5'd0, TWO_PI_Q32, 16'd0};
  // floor(2^67 / TWO_PI_Q32): reciprocal for the pulse count
  localparam logic [32:0] PULSE_RECIP  = 33'((68'd1 << 67) / {33'd0, TWO_PI_Q32});

  localparam logic [7:0] BYTE_ZERO  = 8'h00;
  localparam logic [7:0] BYTE_SOF   = 8'hFD;
  localparam logic [7:0] BYTE_EOF   = 8'h6B;
  localparam logic [7:0] BYTE_SYNC0 = 8'hFF;
  localparam logic [7:0] BYTE_SYNC1 = 8'h66;

  localparam logic [3:0] POS_LAST  = 4'd12;
  localparam logic [3:0] SYNC_LAST = 4'd3;

  localparam int DIV_QW = 42;
  localparam int DIV_DW = 48;
  localparam int DIV_NW = DIV_QW + DIV_DW;
  localparam logic [5:0] DIV_LAST = 6'(DIV_QW - 1);

  typedef struct packed {
    logic [7:0]  geared_limit;
    logic [15:0] gear_ratio;
    logic [7:0]  default_accel;
    logic [15:0] pulses_per_turn;
  } cfg_t;

  typedef struct packed {
    logic        sync_frame;
    logic [7:0]  dev_addr;
    logic        dir;
    logic [15:0] vel;
    logic [7:0]  acc;
    logic [31:0] pulses;
    logic        multi_sync;
  } frame_t;

endpackage

/* sv/spfb_cmd_if.sv */
// ----------------------------------------------------------------------------
// spfb_cmd_if
// Command channel: one motor command per beat.
// ----------------------------------------------------------------------------
interface spfb_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  dev_addr;
  logic signed [31:0] angle;
  logic [15:0] speed;
  logic [31:0] duration;
  logic        multi_sync;

  modport source (output valid, opcode, dev_addr, angle, speed, duration, multi_sync,
                  input ready);
  modport sink (input valid, opcode, dev_addr, angle, speed, duration, multi_sync,
                output ready);
endinterface

/* sv/spfb_byte_if.sv */
// ----------------------------------------------------------------------------
// spfb_byte_if
// Frame byte channel: one frame byte per beat.
// ----------------------------------------------------------------------------
interface spfb_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, frame_byte, last_byte, input ready);
  modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

/* sv/stepper_position_frame_builder_top.sv */
// ----------------------------------------------------------------------------
// stepper_position_frame_builder_top
// Motor command to serial frame builder with configuration registers.
// Output: one frame byte per cycle while out_frame.ready holds, 13 bytes for
// position frames, 4 for sync. Front occupancy per command: a sync command goes
// straight to push; a velocity command on a geared motor needs no divider pass,
// on other motors one pass, a timed command up to two. Sustained rate is the
// slower of front and serializer; first byte goes through queue and serializer.
// Synchronous reset restores register defaults, empties queue and serializer.
// ----------------------------------------------------------------------------
module stepper_position_frame_builder_top import spfb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  spfb_cmd_if.sink    in_cmd,
  spfb_byte_if.source out_frame
);

  cfg_t   cfg_r;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  frame_t push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.geared_limit    <= 8'd6;
      cfg_r.gear_ratio      <= 16'd256;
      cfg_r.default_accel   <= 8'd0;
      cfg_r.pulses_per_turn <= 16'd3200;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GEARED_LIMIT: cfg_r.geared_limit    <= cfg_data[7:0];
        CFG_GEAR_RATIO:   cfg_r.gear_ratio      <= cfg_data;
        CFG_DEFAULT_ACC:  cfg_r.default_accel   <= cfg_data[7:0];
        CFG_PULSES_TURN:  cfg_r.pulses_per_turn <= cfg_data;
        default:          cfg_r <= cfg_r;
      endcase
    end
  end

  spfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_cmd     (in_cmd),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  spfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry),
    .pop_ready  (pop_ready)
  );

  spfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop_ready (pop_ready),
    .out_frame (out_frame)
  );

endmodule

/* sv/spfb_div.sv */
// ----------------------------------------------------------------------------
// spfb_div
// Restoring divider, one quotient bit per cycle, fixed quotient width.
// ----------------------------------------------------------------------------
module spfb_div import spfb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [DIV_QW-1:0] quo
);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_QW-1:0] nb_r;
  logic [DIV_QW-1:0] quo_r;
  logic [5:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign trial = {rem_r, nb_r[DIV_QW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[DIV_NW-1:DIV_QW];
      nb_r  <= num[DIV_QW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      nb_r  <= {nb_r[DIV_QW-2:0], 1'b0};
      quo_r <= {quo_r[DIV_QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("divider done held");

endmodule

/* sv/spfb_front.sv */
// ----------------------------------------------------------------------------
// spfb_front
// Accepts commands, classifies them and computes the frame fields.
// ----------------------------------------------------------------------------
module spfb_front import spfb_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  spfb_cmd_if.sink in_cmd,
  output logic    push_valid,
  output frame_t  push_entry,
  input  logic    push_ready
);

  typedef enum logic [22:0] {
    S_IDLE = 23'h000001,
    S_NUM  = 23'h000002,
    S_EDIV = 23'h000004,
    S_PLO  = 23'h000008,
    S_PHI  = 23'h000010,
    S_PCHK = 23'h000020,
    S_RLO  = 23'h000040,
    S_RHI  = 23'h000080,
    S_TLO  = 23'h000100,
    S_THI  = 23'h000200,
    S_PFIX = 23'h000400,
    S_SPD  = 23'h000800,
    S_SQ   = 23'h001000,
    S_KLO  = 23'h002000,
    S_KHI  = 23'h004000,
    S_ACHK = 23'h008000,
    S_ADIV = 23'h010000,
    S_VCHK = 23'h020000,
    S_MLO  = 23'h040000,
    S_MHI  = 23'h080000,
    S_VGO  = 23'h100000,
    S_VDIV = 23'h200000,
    S_PUSH = 23'h400000
  } state_t;

  state_t       state_r, state_nxt, after_pulses;
  opcode_t      op_r;
  logic [7:0]   id_r;
  logic         dir_r;
  logic         geared_r;
  logic         sync_r;
  logic [31:0]  mag_r;
  logic [15:0]  speed_r;
  logic [31:0]  dur_r;
  logic [47:0]  num_r;
  logic [39:0]  eff_r;
  logic [55:0]  prod_r;
  logic [83:0]  rq_r;
  logic [66:0]  tq_r;
  logic [31:0]  pulses_r;
  logic [63:0]  s_r;
  logic [80:0]  ks_r;
  logic [68:0]  mx_r;
  logic [15:0]  vel_r;
  logic [7:0]   acc_r;

  logic         accept;
  logic [31:0]  in_mag;
  logic [15:0]  ratio_nz;
  logic [47:0]  vnum;
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic         psat, asat, vsat;
  logic [31:0]  q_est;
  logic [71:0]  prem;
  logic         pfix;
  logic         div_start, div_busy, div_done;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_QW-1:0] quo;
  logic [23:0]  acc_diff;
  logic [42:0]  vel_round;
  logic [15:0]  spd_vel;
  logic [7:0]   div_acc;
  logic [15:0]  div_vel;

  assign in_cmd.ready = (state_r == S_IDLE) || ((state_r == S_PUSH) && push_ready);
  assign accept       = in_cmd.valid && in_cmd.ready;
  assign in_mag       = in_cmd.angle[31] ? 32'(-in_cmd.angle) : in_cmd.angle;
  assign ratio_nz     = (cfg.gear_ratio == 16'd0) ? 16'd1 : cfg.gear_ratio;
  assign vnum         = geared_r ? num_r : {16'd0, mag_r};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_NUM: begin mul_a = mag_r; mul_b = {16'd0, ratio_nz}; end
      S_PLO: begin mul_a = eff_r[31:0]; mul_b = {16'd0, cfg.pulses_per_turn}; end
      S_PHI: begin mul_a = {24'd0, eff_r[39:32]}; mul_b = {16'd0, cfg.pulses_per_turn}; end
      S_RLO: begin mul_a = prod_r[31:0]; mul_b = PULSE_RECIP[31:0]; end
      S_RHI: begin mul_a = {8'd0, prod_r[55:32]}; mul_b = PULSE_RECIP[31:0]; end
      S_TLO: begin mul_a = q_est; mul_b = TWO_PI_Q32[31:0]; end
      S_THI: begin mul_a = q_est; mul_b = {29'd0, TWO_PI_Q32[34:32]}; end
      S_SPD: begin mul_a = {16'd0, speed_r}; mul_b = {16'd0, cfg.gear_ratio}; end
      S_SQ:  begin mul_a = dur_r; mul_b = dur_r; end
      S_KLO: begin mul_a = s_r[31:0]; mul_b = {15'd0, ACC_K_Q15}; end
      S_KHI: begin mul_a = s_r[63:32]; mul_b = {15'd0, ACC_K_Q15}; end
      S_MLO: begin mul_a = vnum[31:0]; mul_b = {11'd0, SIXTY_PI_Q16}; end
      S_MHI: begin mul_a = {16'd0, vnum[47:32]}; mul_b = {11'd0, SIXTY_PI_Q16}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign psat = prod_r >= PULSE_SAT;
  assign asat = s_r >= {6'd0, num_r, 10'd0};
  assign vsat = {5'd0, vnum} >= {dur_r, 21'd0};

  // reciprocal estimate is exact or one low; fix up with the remainder
  assign q_est = rq_r[82:51];
  assign prem  = {prod_r, 16'd0} - {5'd0, tq_r};
  assign pfix  = prem >= {37'd0, TWO_PI_Q32};

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_NUM: begin
        div_start = !geared_r;
        div_num   = {50'd0, mag_r, 8'd0};
        div_den   = {32'd0, ratio_nz};
      end
      S_ACHK: begin
        div_start = !asat;
        div_num   = {9'd0, ks_r};
        div_den   = num_r;
      end
      S_VGO: begin
        div_start = 1'b1;
        div_num   = {21'd0, mx_r};
        div_den   = {16'd0, dur_r};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  spfb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  assign spd_vel   = !geared_r ? speed_r :
                     (mul_p[31:24] != 8'd0) ? 16'hFFFF : mul_p[23:8];
  assign acc_diff  = HALF_257_Q15 - quo[23:0];
  assign div_acc   = (quo[26:0] >= {3'd0, HALF_257_Q15}) ? 8'd0 :
                     (acc_diff[23] ? 8'hFF : acc_diff[22:15]);
  assign vel_round = {1'b0, quo} + 43'h0000800000;
  assign div_vel   = geared_r ? ((vel_round[42:40] != 3'd0) ? 16'hFFFF : vel_round[39:24])
                              : ((quo[41:32] != 10'd0) ? 16'hFFFF : quo[31:16]);

  always_comb begin
    if (op_r == OP_VEL)
      after_pulses = S_SPD;
    else if (geared_r && (mag_r != 32'd0))
      after_pulses = S_SQ;
    else
      after_pulses = S_VCHK;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: state_nxt = state_r;
      S_NUM:  state_nxt = geared_r ? S_PLO : S_EDIV;
      S_EDIV: state_nxt = div_done ? S_PLO : S_EDIV;
      S_PLO:  state_nxt = S_PHI;
      S_PHI:  state_nxt = S_PCHK;
      S_PCHK: state_nxt = psat ? after_pulses : S_RLO;
      S_RLO:  state_nxt = S_RHI;
      S_RHI:  state_nxt = S_TLO;
      S_TLO:  state_nxt = S_THI;
      S_THI:  state_nxt = S_PFIX;
      S_PFIX: state_nxt = after_pulses;
      S_SPD:  state_nxt = S_PUSH;
      S_SQ:   state_nxt = S_KLO;
      S_KLO:  state_nxt = S_KHI;
      S_KHI:  state_nxt = S_ACHK;
      S_ACHK: state_nxt = asat ? S_VCHK : S_ADIV;
      S_ADIV: state_nxt = div_done ? S_VCHK : S_ADIV;
      S_VCHK: state_nxt = ((mag_r == 32'd0) || vsat) ? S_PUSH : S_MLO;
      S_MLO:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_VGO;
      S_VGO:  state_nxt = S_VDIV;
      S_VDIV: state_nxt = div_done ? S_PUSH : S_VDIV;
      S_PUSH: state_nxt = push_ready ? S_IDLE : S_PUSH;
      default: state_nxt = S_IDLE;
    endcase
    if (accept) begin
      case (opcode_t'(in_cmd.opcode))
        OP_VEL, OP_TIMED: state_nxt = S_NUM;
        OP_SYNC:          state_nxt = S_PUSH;
        default:          state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= opcode_t'(in_cmd.opcode);
      id_r     <= in_cmd.dev_addr;
      dir_r    <= !in_cmd.angle[31] && (in_cmd.angle != 32'sd0);
      geared_r <= in_cmd.dev_addr < cfg.geared_limit;
      sync_r   <= in_cmd.multi_sync;
      mag_r    <= in_mag;
      speed_r  <= in_cmd.speed;
      dur_r    <= in_cmd.duration;
      acc_r    <= 8'd0;
    end else begin
      case (state_r)
        S_NUM: begin
          num_r <= mul_p[47:0];
          eff_r <= {8'd0, mag_r};
        end
        S_EDIV: if (div_done) eff_r <= quo[39:0];
        S_PLO:  prod_r <= 56'(mul_p);
        S_PHI:  prod_r <= prod_r + {mul_p[23:0], 32'd0};
        S_PCHK: if (psat) pulses_r <= 32'hFFFF_FFFF;
        S_RLO:  rq_r <= 84'(mul_p) + (PULSE_RECIP[32] ? {prod_r[51:0], 32'd0} : 84'd0);
        S_RHI:  rq_r <= rq_r + {mul_p[51:0], 32'd0};
        S_TLO:  tq_r <= 67'(mul_p);
        S_THI:  tq_r <= tq_r + {mul_p[34:0], 32'd0};
        S_PFIX: pulses_r <= q_est + {31'd0, pfix};
        S_SPD: begin
          vel_r <= spd_vel;
          acc_r <= geared_r ? cfg.default_accel : 8'd0;
        end
        S_SQ:   s_r <= mul_p;
        S_KLO:  ks_r <= 81'(mul_p);
        S_KHI:  ks_r <= ks_r + {mul_p[48:0], 32'd0};
        S_ADIV: if (div_done) acc_r <= div_acc;
        S_VCHK: begin
          if (mag_r == 32'd0) vel_r <= 16'd0;
          else if (vsat)      vel_r <= 16'hFFFF;
        end
        S_MLO:  mx_r <= 69'(mul_p);
        S_MHI:  mx_r <= mx_r + {mul_p[36:0], 32'd0};
        S_VDIV: if (div_done) vel_r <= div_vel;
        default: begin
        end
      endcase
    end
  end

  assign push_valid = (state_r == S_PUSH);
  always_comb begin
    push_entry.sync_frame = (op_r == OP_SYNC);
    push_entry.dev_addr   = id_r;
    push_entry.dir        = dir_r;
    push_entry.vel        = vel_r;
    push_entry.acc        = acc_r;
    push_entry.pulses     = pulses_r;
    push_entry.multi_sync = sync_r;
  end

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EDIV) || (state_r == S_ADIV) || (state_r == S_VDIV)) && !div_done
    |-> div_busy)
    else $error("waiting on an idle divider");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider reused while busy");
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid && $stable(push_entry))
    else $error("frame entry dropped while stalled");

endmodule

/* sv/spfb_queue.sv */
// ----------------------------------------------------------------------------
// spfb_queue
// Two-entry queue of computed frames between front and back.
// ----------------------------------------------------------------------------
module spfb_queue import spfb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  input  frame_t push_entry,
  output logic   push_ready,
  output logic   pop_valid,
  output frame_t pop_entry,
  input  logic   pop_ready
);

  frame_t     ent_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_entry  = ent_r[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wr_r <= !wr_r;
      if (do_pop)  rd_r <= !rd_r;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent_r[wr_r] <= push_entry;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue overflow");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_r == rd_r))
    else $error("queue pointers out of step");

endmodule

/* sv/spfb_back.sv */
// ----------------------------------------------------------------------------
// spfb_back
// Serializes one frame entry into its frame bytes.
// ----------------------------------------------------------------------------
module spfb_back import spfb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   pop_valid,
  input  frame_t pop_entry,
  output logic   pop_ready,
  spfb_byte_if.source out_frame
);

  frame_t     cur_r;
  logic [3:0] idx_r;
  logic       busy_r;
  logic       last;
  logic       beat;
  logic [7:0] pos_byte, sync_byte;

  assign last = (idx_r == (cur_r.sync_frame ? SYNC_LAST : POS_LAST));
  assign beat = busy_r && out_frame.ready;
  assign pop_ready = !busy_r || (beat && last);

  always_comb begin
    case (idx_r)
      4'd0:    pos_byte = cur_r.dev_addr;
      4'd1:    pos_byte = BYTE_SOF;
      4'd2:    pos_byte = {7'd0, cur_r.dir};
      4'd3:    pos_byte = cur_r.vel[15:8];
      4'd4:    pos_byte = cur_r.vel[7:0];
      4'd5:    pos_byte = cur_r.acc;
      4'd6:    pos_byte = cur_r.pulses[31:24];
      4'd7:    pos_byte = cur_r.pulses[23:16];
      4'd8:    pos_byte = cur_r.pulses[15:8];
      4'd9:    pos_byte = cur_r.pulses[7:0];
      4'd10:   pos_byte = BYTE_ZERO;
      4'd11:   pos_byte = {7'd0, cur_r.multi_sync};
      4'd12:   pos_byte = BYTE_EOF;
      default: pos_byte = BYTE_ZERO;
    endcase
    case (idx_r)
      4'd0:    sync_byte = BYTE_ZERO;
      4'd1:    sync_byte = BYTE_SYNC0;
      4'd2:    sync_byte = BYTE_SYNC1;
      4'd3:    sync_byte = BYTE_EOF;
      default: sync_byte = BYTE_ZERO;
    endcase
  end

  assign out_frame.valid      = busy_r;
  assign out_frame.frame_byte = cur_r.sync_frame ? sync_byte : pos_byte;
  assign out_frame.last_byte  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
    end else if (pop_ready && pop_valid) begin
      busy_r <= 1'b1;
      idx_r  <= 4'd0;
    end else if (beat) begin
      if (last) busy_r <= 1'b0;
      else      idx_r  <= idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_ready && pop_valid) cur_r <= pop_entry;
  end

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    beat && last && !pop_valid |=> !busy_r)
    else $error("serializer stuck after last beat");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= POS_LAST)
    else $error("byte index out of range");

endmodule
